// File: hw/rtl/gsbc_pkg.sv
// gyro still-bias calibrator: shared widths, constants, phase and csr codes
// used by every module of the block; depends on nothing
package gsbc_pkg;

   localparam int NUM_AXES    = 3;
   localparam int RAW_W       = 16;
   localparam int THR_W       = 16;
   localparam int CNT_W       = 10;
   localparam int SUM_W       = 25;
   localparam int RATE_W      = 21;
   localparam int Q_FRAC      = 4;
   localparam int AVG_SAMPLES = 500;

   // reciprocal sizing for the mean: numerator is |sum| in Q4, below 2**NUM_W
   // a shift of NUM_W + DIV_W keeps the rounded-up reciprocal exact for it
   localparam int     NUM_W       = SUM_W + Q_FRAC;
   localparam int     DIV_W       = $clog2(AVG_SAMPLES + 1);
   localparam int     RECIP_SHIFT = NUM_W + DIV_W;
   localparam int     RECIP_W     = NUM_W + 2;
   localparam longint RECIP_MUL   =
      ((longint'(1) << RECIP_SHIFT) + longint'(AVG_SAMPLES) - 1) / longint'(AVG_SAMPLES);

   // port sizing
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = ((NUM_AXES * RAW_W + 7) / 8) * 8;
   localparam int RSP_BITS   = 2 + CNT_W + NUM_AXES * RATE_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   typedef logic signed [RAW_W-1:0]  raw_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic signed [RATE_W-1:0] rate_type;
   typedef logic [CNT_W-1:0]         count_type;
   typedef logic [THR_W-1:0]         thresh_type;

   localparam thresh_type THRESH_RESET = thresh_type'(8);
   localparam count_type  SETTLE_RESET = count_type'(100);
   localparam count_type  AVG_COUNT    = count_type'(AVG_SAMPLES);

   localparam sum_type SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam sum_type SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   // calibration phase; the unused code behaves as calibrated
   typedef enum logic [1:0] {
      PH_WAIT = 2'd0,
      PH_AVG  = 2'd1,
      PH_DONE = 2'd2
   } phase_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_STILL_THRESHOLD = 2'd0,
      CSR_SETTLE_COUNT    = 2'd1
   } csr_index_type;

   // per-sample status from the tracker to the result stage
   typedef struct packed {
      phase_type phase;
      count_type progress;
      logic      fix;
   } track_status_type;

endpackage

// File: hw/rtl/gyro_still_bias_calibrator_core.sv
// top level of the gyro still-bias calibrator: stream ports, csr registers,
// result register and offset units; depends on gsbc_pkg, gsbc_track, gsbc_bias_div
//
//   port group | dir | payload (lowest bits first)
//   req_       | in  | raw_x[15:0] raw_y[31:16] raw_z[47:32]
//   rsp_       | out | phase[1:0] progress[11:2] rate_x[32:12] rate_y[53:33] rate_z[74:54]
//   csr_       | in  | index 0 still_threshold, index 1 settle_count
//
// one sample per cycle while rsp_ is taken and no offset unit is busy; each req
// transfer loads the result register behind rsp_tvalid; the sample that ends
// calibration waits while the three offset units scale the sums (reciprocal
// multiply, then sign); synchronous reset, no clearing pass; a stalled rsp_ holds the
// result register and req_tready drops only while that register is full and not taken
module gyro_still_bias_calibrator_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // raw_x, raw_y, raw_z
   input  logic [gsbc_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // phase, progress, rate_x, rate_y, rate_z, zero pad
   output logic [gsbc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_we,
   input  logic [gsbc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [gsbc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import gsbc_pkg::*;

   thresh_type thresh_ff;
   count_type  settle_ff;

   logic             accept_w;
   logic             rsp_xfer_w;
   logic             busy_any_w;
   raw_type          sample_w [NUM_AXES];
   track_status_type status_w;
   sum_type          sum_w    [NUM_AXES];
   logic             busy_w   [NUM_AXES];
   rate_type         offset_w [NUM_AXES];
   rate_type         rate_w   [NUM_AXES];

   logic      res_valid_ff;
   phase_type res_phase_ff;
   count_type res_prog_ff;
   raw_type   res_raw_ff [NUM_AXES];

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
         settle_ff <= SETTLE_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_STILL_THRESHOLD: thresh_ff <= csr_wdata[THR_W-1:0];
            CSR_SETTLE_COUNT:    settle_ff <= csr_wdata[CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // handshake
   always_comb begin
      busy_any_w = 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
         busy_any_w = busy_any_w | busy_w[i];
      end
   end

   assign rsp_tvalid = res_valid_ff && !busy_any_w;
   assign rsp_xfer_w = rsp_tvalid && rsp_tready;
   assign req_tready = !res_valid_ff || rsp_xfer_w;
   assign accept_w   = req_tvalid && req_tready;

   // unpack the sample
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         sample_w[i] = req_tdata[i*RAW_W +: RAW_W];
      end
   end

   gsbc_track u_track (
      .clock           (clock),
      .reset           (reset),
      .step            (accept_w),
      .sample          (sample_w),
      .still_threshold (thresh_ff),
      .settle_count    (settle_ff),
      .status          (status_w),
      .sum             (sum_w)
   );

   // offset units, started by the transfer that ends averaging
   for (genvar g = 0; g < NUM_AXES; g++) begin : g_div
      gsbc_bias_div u_div (
         .clock  (clock),
         .reset  (reset),
         .start  (accept_w && status_w.fix),
         .sum    (sum_w[g]),
         .busy   (busy_w[g]),
         .offset (offset_w[g])
      );
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (accept_w) begin
         res_valid_ff <= 1'b1;
      end else if (rsp_xfer_w) begin
         res_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_w) begin
         res_phase_ff <= status_w.phase;
         res_prog_ff  <= status_w.progress;
         res_raw_ff   <= sample_w;
      end
   end

   // bias-corrected rate in Q4
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         rate_w[i] = rate_type'({res_raw_ff[i][RAW_W-1], res_raw_ff[i], Q_FRAC'(0)})
                     - offset_w[i];
      end
   end

   assign rsp_tdata = {(RSP_DATA_W - RSP_BITS)'(0), rate_w[2], rate_w[1], rate_w[0],
                       res_prog_ff, res_phase_ff};

endmodule

// File: hw/rtl/gsbc_track.sv
// stillness detection, phase sequencing and per-axis sum accumulation
// depends on gsbc_pkg
module gsbc_track (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  gsbc_pkg::raw_type          sample [gsbc_pkg::NUM_AXES],
   input  gsbc_pkg::thresh_type       still_threshold,
   input  gsbc_pkg::count_type        settle_count,
   output gsbc_pkg::track_status_type status,
   output gsbc_pkg::sum_type          sum [gsbc_pkg::NUM_AXES]
);
   import gsbc_pkg::*;

   phase_type phase_ff, phase_in;
   count_type cnt_ff, cnt_in;
   logic      have_prev_ff;
   raw_type   prev_ff [NUM_AXES];
   sum_type   sum_ff  [NUM_AXES];
   sum_type   sum_in  [NUM_AXES];
   sum_type   sat_w   [NUM_AXES];

   logic signed [RAW_W:0] diff_w [NUM_AXES];
   logic [RAW_W:0]        mag_w  [NUM_AXES];
   logic signed [SUM_W:0] acc_w  [NUM_AXES];
   logic                  moved_w;
   logic                  still_w;
   logic                  fix_w;

   // per-axis change against the previous sample
   always_comb begin
      moved_w = 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
         diff_w[i] = (RAW_W+1)'(sample[i]) - (RAW_W+1)'(prev_ff[i]);
         mag_w[i]  = diff_w[i][RAW_W] ? (RAW_W+1)'(-diff_w[i]) : (RAW_W+1)'(diff_w[i]);
         if (mag_w[i][RAW_W-1:0] > still_threshold) begin
            moved_w = 1'b1;
         end
      end
      still_w = have_prev_ff && !moved_w;
   end

   // saturating sum update
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         acc_w[i] = (SUM_W+1)'(sum_ff[i]) + (SUM_W+1)'(sample[i]);
         if (acc_w[i][SUM_W] != acc_w[i][SUM_W-1]) begin
            sat_w[i] = acc_w[i][SUM_W] ? SUM_MIN : SUM_MAX;
         end else begin
            sat_w[i] = acc_w[i][SUM_W-1:0];
         end
      end
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      sum_in   = sum_ff;
      fix_w    = 1'b0;
      case (phase_ff)
         PH_WAIT: begin
            if (still_w) begin
               if (cnt_ff >= settle_count) begin
                  phase_in = PH_AVG;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end else begin
               cnt_in = '0;
            end
         end
         PH_AVG: begin
            if (still_w) begin
               if (cnt_ff < AVG_COUNT) begin
                  sum_in = sat_w;
                  cnt_in = cnt_ff + 1'b1;
               end else begin
                  fix_w    = 1'b1;
                  phase_in = PH_DONE;
                  cnt_in   = '0;
               end
            end else begin
               for (int i = 0; i < NUM_AXES; i++) begin
                  sum_in[i] = '0;
               end
               phase_in = PH_WAIT;
               cnt_in   = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // outputs: status after this sample, sums before it
   always_comb begin
      status.phase    = phase_in;
      status.progress = cnt_in;
      status.fix      = fix_w;
      sum             = sum_ff;
   end

   // state registers, advanced on each input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WAIT;
         cnt_ff       <= '0;
         have_prev_ff <= 1'b0;
         for (int i = 0; i < NUM_AXES; i++) begin
            sum_ff[i]  <= '0;
            prev_ff[i] <= '0;
         end
      end else if (step) begin
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         have_prev_ff <= 1'b1;
         sum_ff       <= sum_in;
         prev_ff      <= sample;
      end
   end

endmodule

// File: hw/rtl/gsbc_bias_div.sv
// one-axis offset unit: sum*16 over the sample count by reciprocal multiply,
// truncated toward zero, busy until the signed offset is registered; depends on gsbc_pkg
module gsbc_bias_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  gsbc_pkg::sum_type  sum,
   output logic               busy,
   output gsbc_pkg::rate_type offset
);
   import gsbc_pkg::*;

   localparam int                 PROD_W = SUM_W + RECIP_W;
   localparam int                 Q_LSB  = RECIP_SHIFT - Q_FRAC;
   localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'(RECIP_MUL);

   logic [SUM_W-1:0]  mag_ff;
   logic              neg_ff;
   logic              busy_ff;
   logic              scaled_ff;
   logic [RATE_W-1:0] quo_ff;
   rate_type          offset_ff;

   logic [SUM_W-1:0]  mag_w;
   logic [PROD_W-1:0] prod_w;

   // magnitude of the captured sum
   assign mag_w = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

   // |sum| * 16 / AVG_SAMPLES as a multiply by the scaled reciprocal
   assign prod_w = PROD_W'(mag_ff) * PROD_W'(RECIP);

   // sequencing: capture, multiply, apply the sign
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         scaled_ff <= 1'b0;
         offset_ff <= '0;
      end else if (start) begin
         busy_ff   <= 1'b1;
         scaled_ff <= 1'b0;
      end else if (busy_ff) begin
         if (scaled_ff) begin
            busy_ff   <= 1'b0;
            scaled_ff <= 1'b0;
            offset_ff <= neg_ff ? rate_type'(-quo_ff) : rate_type'(quo_ff);
         end else begin
            scaled_ff <= 1'b1;
         end
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      if (start) begin
         mag_ff <= mag_w;
         neg_ff <= sum[SUM_W-1];
      end else if (busy_ff && !scaled_ff) begin
         quo_ff <= prod_w[Q_LSB +: RATE_W];
      end
   end

   assign busy   = busy_ff;
   assign offset = offset_ff;

endmodule

// File: hw/rtl/gsbc_checker.sv
// port-level checks for the gyro still-bias calibrator and their bind
// depends on gsbc_pkg and the top level's ports
module gsbc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [gsbc_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [gsbc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            csr_we,
   input logic [gsbc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input logic [gsbc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import gsbc_pkg::*;

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("rsp payload changed while stalled");

   // the unused phase code never shows
   a_phase_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] != 2'd3))
      else $error("rsp phase code out of range");

   // calibrated results carry no progress count
   a_done_progress: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[1:0] == PH_DONE)) |-> (rsp_tdata[CNT_W+1:2] == '0))
      else $error("progress nonzero in calibrated phase");

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_tvalid && req_tready))
      else $error("result pending after reset");

   // an item can only enter when the result side is empty or draining
   a_accept_path: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input accepted over a stalled result");

endmodule

bind gyro_still_bias_calibrator_core gsbc_checker u_gsbc_checker (.*);

// File: dv/tb_top.sv
// self-checking testbench for gyro_still_bias_calibrator_core: stream driver,
// result monitor, csr writes and a per-sample predictor of the bias calibration
// depends on gsbc_pkg and the core rtl only
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import gsbc_pkg::*;

   // one sample: x in the lowest bits, matches req_tdata
   typedef raw_type [NUM_AXES-1:0] sample_type;

   // one result: phase in the lowest bits, matches rsp_tdata below the pad
   typedef struct packed {
      rate_type [NUM_AXES-1:0] rate;
      count_type               progress;
      phase_type               phase;
   } rate_result_type;

   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED = 2'd3;
   localparam int RAW_MAX     = 32767;
   localparam int RAW_MIN     = -32768;
   localparam int THR_FULL    = 65535;
   localparam int IDLE_PCT    = 16;
   localparam int HOLD_CYCLES = 64;
   localparam int STALL_LIMIT = 1000;
   localparam int TAIL_CYCLES = 40;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   sample_type      pending_samples[$];
   rate_result_type expected_rates[$];
   sample_type      last_offered = '0;
   bit              calm         = 1'b0;
   int              fails        = 0;
   int              rates_seen   = 0;
   int              hold_left    = 0;
   int              stall_cycles = 0;

   // predictor state and its copy of the registers
   phase_type exp_phase  = PH_WAIT;
   bit        seen_first = 1'b0;
   int        still_run  = 0;
   int        thr_cfg    = 8;
   int        settle_cfg = 100;
   int        last_raw[NUM_AXES] = '{0, 0, 0};
   int        bias_sum[NUM_AXES] = '{0, 0, 0};
   int        bias_q4[NUM_AXES]  = '{0, 0, 0};

   gyro_still_bias_calibrator_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // expected phase, progress and corrected rates for one accepted sample
   function automatic void predict_rates(sample_type smp);
      int              raw[NUM_AXES];
      bit              quiet;
      int              diff;
      int              acc;
      rate_result_type r;
      for (int i = 0; i < NUM_AXES; i++) raw[i] = $signed(smp[i]);
      if (exp_phase == PH_WAIT || exp_phase == PH_AVG) begin
         quiet = seen_first;
         for (int i = 0; i < NUM_AXES; i++) begin
            diff = raw[i] - last_raw[i];
            if (diff < 0) diff = -diff;
            if (diff > thr_cfg) quiet = 1'b0;
         end
         if (exp_phase == PH_WAIT) begin
            if (!quiet) still_run = 0;
            else if (still_run >= settle_cfg) begin
               exp_phase = PH_AVG;
               still_run = 0;
            end else still_run = (still_run + 1) % 1024;
         end else if (!quiet) begin
            // motion while averaging drops the sums and restarts the wait
            for (int i = 0; i < NUM_AXES; i++) bias_sum[i] = 0;
            exp_phase = PH_WAIT;
            still_run = 0;
         end else if (still_run < AVG_SAMPLES) begin
            for (int i = 0; i < NUM_AXES; i++) begin
               acc = bias_sum[i] + raw[i];
               if (acc > int'(SUM_MAX)) acc = int'(SUM_MAX);
               if (acc < int'(SUM_MIN)) acc = int'(SUM_MIN);
               bias_sum[i] = acc;
            end
            still_run = (still_run + 1) % 1024;
         end else begin
            // mean in q4, truncated toward zero
            for (int i = 0; i < NUM_AXES; i++)
               bias_q4[i] = int'((longint'(bias_sum[i]) * (1 << Q_FRAC)) / AVG_SAMPLES);
            exp_phase = PH_DONE;
            still_run = 0;
         end
      end
      for (int i = 0; i < NUM_AXES; i++) last_raw[i] = raw[i];
      seen_first = 1'b1;
      r.phase    = exp_phase;
      r.progress = count_type'(still_run);
      for (int i = 0; i < NUM_AXES; i++)
         r.rate[i] = rate_type'(raw[i] * (1 << Q_FRAC) - bias_q4[i]);
      expected_rates.push_back(r);
   endfunction

   function automatic void check_field(string name, logic signed [63:0] want,
                                       logic signed [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fails++;
      end
   endfunction

   task automatic compare_rates(rate_result_type got);
      rate_result_type want;
      string           axis_name[NUM_AXES] = '{"rate_x", "rate_y", "rate_z"};
      if (expected_rates.size() == 0) begin
         $error("result transfer with nothing expected, data %h", got);
         fails++;
      end else begin
         want = expected_rates.pop_front();
         check_field("phase", want.phase, got.phase);
         check_field("progress", want.progress, got.progress);
         for (int i = 0; i < NUM_AXES; i++)
            check_field(axis_name[i], $signed(want.rate[i]), $signed(got.rate[i]));
      end
   endtask

   // sample driver: holds an offered sample until its transfer
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_rates(pending_samples.pop_front());
         if (!req_tvalid || req_tready) begin
            if (pending_samples.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_samples[0];
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor with random stalls and two long hold-offs
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            compare_rates(rate_result_type'(rsp_tdata[$bits(rate_result_type)-1:0]));
            rates_seen++;
            if (rates_seen == 150 || rates_seen == 700) hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
         end
      end
   end

   // watchdog: no transfer for too long while work is outstanding
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (pending_samples.size() == 0 && expected_rates.size() == 0)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic sample_type make_sample(int x, int y, int z);
      return {raw_type'(z), raw_type'(y), raw_type'(x)};
   endfunction

   function automatic void offer(sample_type smp);
      pending_samples.push_back(smp);
      last_offered = smp;
   endfunction

   function automatic sample_type any_sample();
      sample_type s;
      for (int i = 0; i < NUM_AXES; i++) s[i] = raw_type'($urandom);
      return s;
   endfunction

   // every axis moves by at most thr, often by exactly thr
   function automatic sample_type still_after(sample_type p, int thr);
      sample_type s;
      int         d;
      int         v;
      for (int i = 0; i < NUM_AXES; i++) begin
         if ($urandom_range(0, 7) == 0) d = $urandom_range(0, 1) ? thr : -thr;
         else d = int'($urandom_range(0, 2 * thr)) - thr;
         v = $signed(p[i]) + d;
         if (v > RAW_MAX) v = RAW_MAX;
         if (v < RAW_MIN) v = RAW_MIN;
         s[i] = raw_type'(v);
      end
      return s;
   endfunction

   // one axis jumps past thr, the others stay still
   function automatic sample_type moved_from(sample_type p, int thr);
      sample_type s;
      int         a;
      int         mag;
      int         v;
      s   = still_after(p, thr);
      a   = $urandom_range(0, NUM_AXES - 1);
      mag = thr + 1 + $urandom_range(0, 64);
      if (mag > THR_FULL) mag = THR_FULL;
      v = $signed(p[a]) + mag;
      if (v > RAW_MAX) v = $signed(p[a]) - mag;
      if (v < RAW_MIN) v = ($signed(p[a]) < 0) ? RAW_MAX : RAW_MIN;
      s[a] = raw_type'(v);
      return s;
   endfunction

   function automatic int pick_threshold(bit allow_full);
      case ($urandom_range(0, 4))
         0:       return 0;
         1:       return $urandom_range(1, 16);
         2:       return $urandom_range(17, 600);
         3:       return $urandom_range(601, 20000);
         default: return allow_full ? THR_FULL : $urandom_range(1, 64);
      endcase
   endfunction

   task automatic wait_until_quiet();
      while (pending_samples.size() != 0 || expected_rates.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_STILL_THRESHOLD: thr_cfg = int'(thresh_type'(val));
         CSR_SETTLE_COUNT:    settle_cfg = int'(count_type'(val));
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int thr;
      int settle;
      int run;
      bit prev_full;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: first sample, threshold edge, motion
      @(negedge clock);
      offer(make_sample(RAW_MIN, RAW_MAX, -1));
      offer(make_sample(RAW_MIN, RAW_MAX, -1));
      offer(make_sample(RAW_MIN + 8, RAW_MAX - 8, 7));
      offer(make_sample(RAW_MIN + 17, RAW_MAX - 8, 7));

      // full threshold, settle masked to zero, write to an unused index
      wait_until_quiet();
      write_csr(CSR_STILL_THRESHOLD, 16'hFFFF);
      write_csr(CSR_SETTLE_COUNT, 16'hFC00);
      write_csr(CSR_UNUSED, 16'h0001);
      @(negedge clock);
      offer(make_sample(RAW_MAX, RAW_MIN, 0));
      offer(make_sample(RAW_MIN, RAW_MAX, RAW_MIN));
      offer(make_sample(RAW_MAX, RAW_MIN, RAW_MAX));
      offer(make_sample(0, 0, 0));
      offer(make_sample(-1, -1, -1));

      // zero threshold: only repeats are still, motion while averaging
      wait_until_quiet();
      write_csr(CSR_STILL_THRESHOLD, 16'h0000);
      @(negedge clock);
      offer(make_sample(-1, -1, -1));
      offer(make_sample(-1, -1, 0));
      offer(make_sample(-1, -1, 0));
      offer(make_sample(-1, -1, 0));
      offer(make_sample(21845, -21846, 1));

      // random episodes: noise, a still run of random length, then motion
      prev_full = 1'b1;
      for (int ep = 0; ep < 7; ep++) begin
         thr       = pick_threshold(!prev_full);
         prev_full = (thr == THR_FULL);
         settle    = (ep == 1) ? 1023 : $urandom_range(0, 30);
         wait_until_quiet();
         write_csr(CSR_STILL_THRESHOLD, CSR_DATA_W'(thr));
         write_csr(CSR_SETTLE_COUNT, CSR_DATA_W'(settle));
         @(negedge clock);
         if (thr != THR_FULL) offer(moved_from(last_offered, thr));
         repeat ($urandom_range(0, 4)) offer(any_sample());
         run = (settle == 1023) ? 40 : $urandom_range(0, settle + 61);
         repeat (run) offer(still_after(last_offered, thr));
         if (thr != THR_FULL) offer(moved_from(last_offered, thr));
      end

      // full calibration: a still run long enough to fix the offsets
      thr    = pick_threshold(1'b1);
      settle = $urandom_range(0, 12);
      wait_until_quiet();
      write_csr(CSR_STILL_THRESHOLD, CSR_DATA_W'(thr));
      write_csr(CSR_SETTLE_COUNT, CSR_DATA_W'(settle));
      @(negedge clock);
      if (thr != THR_FULL) offer(moved_from(last_offered, thr));
      repeat (settle + AVG_SAMPLES + 5) offer(still_after(last_offered, thr));
      calm = 1'b1;
      while (pending_samples.size() > 250) @(negedge clock);
      calm = 1'b0;

      // calibrated: registers no longer matter, offsets stay put
      wait_until_quiet();
      write_csr(CSR_STILL_THRESHOLD, 16'h0000);
      write_csr(CSR_SETTLE_COUNT, 16'h03FF);
      @(negedge clock);
      for (int c = 0; c < 8; c++)
         offer(make_sample(c[0] ? RAW_MAX : RAW_MIN, c[1] ? RAW_MAX : RAW_MIN,
                           c[2] ? RAW_MAX : RAW_MIN));
      repeat (200) begin
         if ($urandom_range(0, 1)) offer(any_sample());
         else offer(still_after(last_offered, $urandom_range(0, 300)));
      end

      wait_until_quiet();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fails == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/gsbc_pkg.sv
hw/rtl/gsbc_track.sv
hw/rtl/gsbc_bias_div.sv
hw/rtl/gyro_still_bias_calibrator_core.sv
hw/rtl/gsbc_checker.sv
dv/tb_top.sv
